@@ rtl/qrs_pkg.sv @@
// Shared constants and result codes for the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
   localparam int DEF_COEF_WIDTH = 16;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int OUT_WIDTH      = 35;

   typedef enum logic [1:0] {
      KIND_REAL    = 2'd0,
      KIND_COMPLEX = 2'd1,
      KIND_LINEAR  = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;
endpackage
`default_nettype wire

@@ rtl/quadratic_root_solver.sv @@
// Top level of the quadratic root solver: coefficient decode, discriminant, root and divide chains.
// Stages in order: magnitudes, products, discriminant, sqrt cells, numerators, divider cells, output.
// Throughput: one word per cycle; every stage moves together while the output register can take data.
// The square root chain settles one root bit per cell, the divider chain one quotient bit per cell.
// Reset is synchronous and active high; it clears the valid bits of every stage.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver #(
   parameter int COEF_WIDTH = qrs_pkg::DEF_COEF_WIDTH,
   parameter int FRAC_BITS  = qrs_pkg::DEF_FRAC_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // coef_a, coef_b, coef_c from the lowest bit up, then zero fill
   input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // first_value, second_value from the lowest bit up, then zero fill
   output logic [((2*qrs_pkg::OUT_WIDTH+7)/8)*8-1:0]   rsp_tdata,
   // kind
   output logic [1:0]                                  rsp_tuser
);
   import qrs_pkg::*;

   localparam int CW     = COEF_WIDTH;
   localparam int F      = FRAC_BITS;
   localparam int PW     = 2*CW;
   localparam int DMW    = 2*CW + 1;
   localparam int SW     = CW + 1 + F;
   localparam int NW     = CW + F + 2;
   localparam int DW     = CW + 1;
   localparam int SIDE_W = 3*CW + 6;
   localparam int RSP_W  = ((2*OUT_WIDTH+7)/8)*8;
   localparam int EW     = (NW > OUT_WIDTH ? NW : OUT_WIDTH) + 1;

   logic en;

   // stage 0: magnitudes
   logic          v0_ff, an0_ff, bn0_ff, cn0_ff;
   logic [CW-1:0] am0_ff, bm0_ff, cm0_ff, ar, br, cr;

   // stage 1: products
   logic          v1_ff, an1_ff, bn1_ff, cn1_ff;
   logic [CW-1:0] am1_ff, bm1_ff, cm1_ff;
   logic [PW-1:0] bb1_ff, ac1_ff;

   // stage 2: discriminant
   logic              v2_ff;
   logic [DMW-1:0]    d2_ff, d2_in, four_ac, bbx;
   logic [SIDE_W-1:0] side2_ff, side2_in;
   logic              dneg_in;

   always_comb begin
      en         = !rsp_tvalid || rsp_tready;
      req_tready = en;
      ar = req_tdata[CW-1:0];
      br = req_tdata[2*CW-1:CW];
      cr = req_tdata[3*CW-1:2*CW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_comb begin
      four_ac = {ac1_ff[PW-2:0], 2'b00};
      bbx     = {1'b0, bb1_ff};
      dneg_in = (ac1_ff != '0) && (an1_ff == cn1_ff) && (bbx < four_ac);
      if (ac1_ff == '0 || an1_ff != cn1_ff) begin
         d2_in = bbx + four_ac;
      end else if (!dneg_in) begin
         d2_in = bbx - four_ac;
      end else begin
         d2_in = four_ac - bbx;
      end
      side2_in = {am1_ff == '0, bm1_ff == '0, an1_ff, bn1_ff, cn1_ff, dneg_in,
                  am1_ff, bm1_ff, cm1_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         an0_ff   <= ar[CW-1];
         bn0_ff   <= br[CW-1];
         cn0_ff   <= cr[CW-1];
         am0_ff   <= ar[CW-1] ? (~ar + 1'b1) : ar;
         bm0_ff   <= br[CW-1] ? (~br + 1'b1) : br;
         cm0_ff   <= cr[CW-1] ? (~cr + 1'b1) : cr;
         an1_ff   <= an0_ff;
         bn1_ff   <= bn0_ff;
         cn1_ff   <= cn0_ff;
         am1_ff   <= am0_ff;
         bm1_ff   <= bm0_ff;
         cm1_ff   <= cm0_ff;
         bb1_ff   <= bm0_ff * bm0_ff;
         ac1_ff   <= am0_ff * cm0_ff;
         d2_ff    <= d2_in;
         side2_ff <= side2_in;
      end
   end

   // square root chain
   logic              sq_valid [SW+1];
   logic [SW+1:0]     sq_rem   [SW+1];
   logic [SW-1:0]     sq_root  [SW+1];
   logic [2*SW-1:0]   sq_rad   [SW+1];
   logic [SIDE_W-1:0] sq_side  [SW+1];

   assign sq_valid[0] = v2_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_rad[0]   = (2*SW)'(d2_ff) << (2*F);
   assign sq_side[0]  = side2_ff;

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      qrs_sqrt_cell #(.SW(SW), .SIDE_W(SIDE_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (sq_valid[i]),
         .in_rem   (sq_rem[i]),
         .in_root  (sq_root[i]),
         .in_rad   (sq_rad[i]),
         .in_side  (sq_side[i]),
         .out_valid(sq_valid[i+1]),
         .out_rem  (sq_rem[i+1]),
         .out_root (sq_root[i+1]),
         .out_rad  (sq_rad[i+1]),
         .out_side (sq_side[i+1])
      );
   end

   // stage 3: numerators and divisor
   logic          za, zb, an, bn, cn, dneg;
   logic [CW-1:0] am, bm, cm;
   logic [NW-1:0] pb, sx, cx, n1_in, n2_in, n1_ff, n2_ff;
   logic [DW-1:0] den_in, den_ff;
   logic          neg1_in, neg2_in, neg1_ff, neg2_ff, v3_ff;
   logic [1:0]    kind_in, kind3_ff;

   always_comb begin
      {za, zb, an, bn, cn, dneg, am, bm, cm} = sq_side[SW];
      pb = NW'(bm) << F;
      sx = NW'(sq_root[SW]);
      cx = NW'(cm) << F;
      n1_in = '0; n2_in = '0; neg1_in = 1'b0; neg2_in = 1'b0;
      if (za) begin
         kind_in = zb ? KIND_NONE : KIND_LINEAR;
         den_in  = DW'(bm);
         n1_in   = cx;
         n2_in   = cx;
         neg1_in = !(cn ^ bn);
         neg2_in = !(cn ^ bn);
      end else if (dneg) begin
         kind_in = KIND_COMPLEX;
         den_in  = {am, 1'b0};
         n1_in   = pb;
         neg1_in = !bn ^ an;
         n2_in   = sx;
      end else begin
         kind_in = KIND_REAL;
         den_in  = {am, 1'b0};
         if (bn) begin
            n1_in = pb + sx; neg1_in = an;
            if (pb >= sx) begin
               n2_in = pb - sx; neg2_in = an;
            end else begin
               n2_in = sx - pb; neg2_in = !an;
            end
         end else begin
            n2_in = pb + sx; neg2_in = !an;
            if (pb >= sx) begin
               n1_in = pb - sx; neg1_in = !an;
            end else begin
               n1_in = sx - pb; neg1_in = an;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= sq_valid[SW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff    <= n1_in;
         n2_ff    <= n2_in;
         neg1_ff  <= neg1_in;
         neg2_ff  <= neg2_in;
         den_ff   <= den_in;
         kind3_ff <= kind_in;
      end
   end

   // divider chain
   logic          dv_valid [NW+1];
   logic [DW-1:0] dv_den   [NW+1];
   logic [DW-1:0] dv_rem1  [NW+1];
   logic [NW-1:0] dv_num1  [NW+1];
   logic [DW-1:0] dv_rem2  [NW+1];
   logic [NW-1:0] dv_num2  [NW+1];
   logic [3:0]    dv_side  [NW+1];

   assign dv_valid[0] = v3_ff;
   assign dv_den[0]   = den_ff;
   assign dv_rem1[0]  = '0;
   assign dv_num1[0]  = n1_ff;
   assign dv_rem2[0]  = '0;
   assign dv_num2[0]  = n2_ff;
   assign dv_side[0]  = {kind3_ff, neg1_ff, neg2_ff};

   for (genvar j = 0; j < NW; j++) begin : g_div
      qrs_div_cell #(.NW(NW), .DW(DW), .SIDE_W(4)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (dv_valid[j]),
         .in_den   (dv_den[j]),
         .in_rem1  (dv_rem1[j]),
         .in_num1  (dv_num1[j]),
         .in_rem2  (dv_rem2[j]),
         .in_num2  (dv_num2[j]),
         .in_side  (dv_side[j]),
         .out_valid(dv_valid[j+1]),
         .out_den  (dv_den[j+1]),
         .out_rem1 (dv_rem1[j+1]),
         .out_num1 (dv_num1[j+1]),
         .out_rem2 (dv_rem2[j+1]),
         .out_num2 (dv_num2[j+1]),
         .out_side (dv_side[j+1])
      );
   end

   // output register with saturation
   function automatic logic [OUT_WIDTH-1:0] encode(input logic neg, input logic [NW-1:0] mag);
      logic [EW-1:0] m, lim;
      m   = EW'(mag);
      lim = EW'(1) << (OUT_WIDTH - 1);
      if (neg) begin
         if (m > lim) m = lim;
         m = ~m + 1'b1;
      end else if (m > lim - 1'b1) begin
         m = lim - 1'b1;
      end
      return m[OUT_WIDTH-1:0];
   endfunction

   logic                 rsp_valid_ff;
   logic [1:0]           kind_ff, kind_out;
   logic [OUT_WIDTH-1:0] first_ff, second_ff, first_in, second_in;
   logic                 oneg1, oneg2;

   always_comb begin
      {kind_out, oneg1, oneg2} = dv_side[NW];
      first_in  = encode(oneg1, dv_num1[NW]);
      second_in = encode(oneg2, dv_num2[NW]);
      case (kind_out)
         KIND_NONE: begin
            first_in  = '0;
            second_in = '0;
         end
         KIND_LINEAR: second_in = first_in;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff   <= kind_out;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = RSP_W'({second_ff, first_ff});

`ifndef SYNTHESIS
   a_linear_copy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_LINEAR |-> first_ff == second_ff)
      else $error("Linear root word carries two different values.");
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_NONE |-> first_ff == '0 && second_ff == '0)
      else $error("No-solution word carries non-zero values.");
   a_imag_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_COMPLEX |-> !second_ff[OUT_WIDTH-1])
      else $error("Imaginary magnitude is negative.");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(dv_num1[NW]) && $stable(sq_root[SW]))
      else $error("Chain moved while the output was stalled.");
`endif
endmodule
`default_nettype wire

@@ rtl/qrs_sqrt_cell.sv @@
// One cell of the square root chain: settles one root bit from two radicand bits.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt_cell #(
   parameter int SW     = 33,
   parameter int SIDE_W = 54
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [SW+1:0]     in_rem,
   input  wire logic [SW-1:0]     in_root,
   input  wire logic [2*SW-1:0]   in_rad,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [SW+1:0]          out_rem,
   output logic [SW-1:0]          out_root,
   output logic [2*SW-1:0]        out_rad,
   output logic [SIDE_W-1:0]      out_side
);
   logic              valid_ff;
   logic [SW+1:0]     rem_ff, rem_in;
   logic [SW-1:0]     root_ff, root_in;
   logic [2*SW-1:0]   rad_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [SW+2:0]     shifted, trial, diff;
   logic              take;

   always_comb begin
      shifted = {in_rem[SW:0], in_rad[2*SW-1 -: 2]};
      trial   = {1'b0, in_root, 2'b01};
      diff    = shifted - trial;
      take    = shifted >= trial;
      rem_in  = take ? diff[SW+1:0] : shifted[SW+1:0];
      root_in = {in_root[SW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= {in_rad[2*SW-3:0], 2'b00};
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_rad   = rad_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

@@ rtl/qrs_div_cell.sv @@
// One cell of the divider chain: one quotient bit for each of two numerators.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div_cell #(
   parameter int NW     = 34,
   parameter int DW     = 17,
   parameter int SIDE_W = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [DW-1:0]     in_den,
   input  wire logic [DW-1:0]     in_rem1,
   input  wire logic [NW-1:0]     in_num1,
   input  wire logic [DW-1:0]     in_rem2,
   input  wire logic [NW-1:0]     in_num2,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [DW-1:0]          out_den,
   output logic [DW-1:0]          out_rem1,
   output logic [NW-1:0]          out_num1,
   output logic [DW-1:0]          out_rem2,
   output logic [NW-1:0]          out_num2,
   output logic [SIDE_W-1:0]      out_side
);
   logic              valid_ff;
   logic [DW-1:0]     den_ff, rem1_ff, rem2_ff, rem1_in, rem2_in;
   logic [NW-1:0]     num1_ff, num2_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [DW:0]       r1, r2, d1, d2, den_x;
   logic              q1, q2;

   always_comb begin
      den_x   = {1'b0, in_den};
      r1      = {in_rem1, in_num1[NW-1]};
      r2      = {in_rem2, in_num2[NW-1]};
      d1      = r1 - den_x;
      d2      = r2 - den_x;
      q1      = r1 >= den_x;
      q2      = r2 >= den_x;
      rem1_in = q1 ? d1[DW-1:0] : r1[DW-1:0];
      rem2_in = q2 ? d2[DW-1:0] : r2[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff  <= in_den;
         rem1_ff <= rem1_in;
         rem2_ff <= rem2_in;
         num1_ff <= {in_num1[NW-2:0], q1};
         num2_ff <= {in_num2[NW-2:0], q2};
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_den   = den_ff;
   assign out_rem1  = rem1_ff;
   assign out_num1  = num1_ff;
   assign out_rem2  = rem2_ff;
   assign out_num2  = num2_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

@@ sim/quadratic_root_solver_tb.sv @@
// Self-checking testbench for the quadratic root solver, with a built-in root predictor.
`timescale 1ns / 1ps
module quadratic_root_solver_tb;
   import qrs_pkg::*;

   typedef struct {
      kind_type           kind;
      logic signed [34:0] first_value;
      logic signed [34:0] second_value;
   } roots_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   logic [47:0] coef_queue[$];
   roots_type   expected_roots[$];
   int          mismatches = 0;
   int          send_gap = 0;
   int          sent_count = 0;
   int          recv_stall = 0;
   int          recv_count = 0;

   quadratic_root_solver u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [127:0] int_sqrt(input logic [127:0] x);
      logic [127:0] res;
      logic [127:0] bitv;
      logic [127:0] t;
      res  = '0;
      bitv = 128'd1 << 126;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         t = res + bitv;
         if (x >= t) begin
            x   = x - t;
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [34:0] saturate(input bit neg, input logic [127:0] mag);
      logic [127:0] lim;
      lim = 128'd1 << 34;
      if (neg) begin
         if (mag > lim) mag = lim;
         return 35'(-mag);
      end
      if (mag > lim - 1) mag = lim - 1;
      return mag[34:0];
   endfunction

   function automatic roots_type solve_roots(input logic [47:0] coefs);
      roots_type    r;
      bit           an, bn, cn, dneg, nn;
      logic [127:0] am, bm, cm, bb, four_ac, dmag, s, pb, den, num;
      an = coefs[15];
      bn = coefs[31];
      cn = coefs[47];
      am = an ? 128'(-$signed(coefs[15:0])) : 128'(coefs[15:0]);
      bm = bn ? 128'(-$signed(coefs[31:16])) : 128'(coefs[31:16]);
      cm = cn ? 128'(-$signed(coefs[47:32])) : 128'(coefs[47:32]);
      if (am == 0) begin
         if (bm == 0) begin
            r.kind = KIND_NONE;
            r.first_value = '0;
            r.second_value = '0;
         end else begin
            r.kind = KIND_LINEAR;
            r.first_value = saturate(!(cn ^ bn), (cm << 16) / bm);
            r.second_value = r.first_value;
         end
         return r;
      end
      bb = bm * bm;
      four_ac = (am * cm) << 2;
      dneg = 1'b0;
      if (four_ac == 0 || an != cn) dmag = bb + four_ac;
      else if (bb >= four_ac) dmag = bb - four_ac;
      else begin
         dneg = 1'b1;
         dmag = four_ac - bb;
      end
      s = int_sqrt(dmag << 32);
      pb = bm << 16;
      den = am << 1;
      if (!dneg) begin
         // Signed-magnitude sums of -b*2^F and +/-S.
         if (bn) begin
            nn = 1'b0; num = pb + s;
         end else if (pb >= s) begin
            nn = 1'b1; num = pb - s;
         end else begin
            nn = 1'b0; num = s - pb;
         end
         r.first_value = saturate(nn ^ an, num / den);
         if (!bn) begin
            nn = 1'b1; num = pb + s;
         end else if (pb >= s) begin
            nn = 1'b0; num = pb - s;
         end else begin
            nn = 1'b1; num = s - pb;
         end
         r.second_value = saturate(nn ^ an, num / den);
         r.kind = KIND_REAL;
      end else begin
         r.first_value = saturate(!bn ^ an, pb / den);
         r.second_value = saturate(1'b0, s / den);
         r.kind = KIND_COMPLEX;
      end
      return r;
   endfunction

   function automatic int pick_gap(input int count);
      if ((count % 300) < 60) return 0;
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [47:0] pack_coefs(input int a, input int b, input int c);
      return {c[15:0], b[15:0], a[15:0]};
   endfunction

   // Driver: one word per handshake, predicting its roots when it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_roots.push_back(solve_roots(req_tdata));
            sent_count = sent_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (coef_queue.size() > 0) begin
               req_tdata  <= coef_queue.pop_front();
               req_tvalid <= 1'b1;
               send_gap = pick_gap(sent_count);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure, each word checked against the oldest prediction.
   always @(posedge clock) begin
      roots_type exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            recv_count = recv_count + 1;
            if (expected_roots.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("Unexpected result word: kind %0d data %h", rsp_tuser, rsp_tdata);
            end else begin
               exp_r = expected_roots.pop_front();
               if (rsp_tuser !== exp_r.kind || rsp_tdata[34:0] !== exp_r.first_value
                   || rsp_tdata[69:35] !== exp_r.second_value || rsp_tdata[71:70] !== 2'b00) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display({"Mismatch: expected kind %0d first %0d second %0d, ",
                               "got kind %0d first %0d second %0d"},
                              exp_r.kind, exp_r.first_value, exp_r.second_value, rsp_tuser,
                              $signed(rsp_tdata[34:0]), $signed(rsp_tdata[69:35]));
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall = recv_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall = pick_gap(recv_count + 150);
         end
      end
   end

   initial begin
      int a, b, c, k, mode, i;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      coef_queue.push_back(pack_coefs(0, 0, 0));
      coef_queue.push_back(pack_coefs(0, 0, -32768));
      coef_queue.push_back(pack_coefs(0, 3, -7));
      coef_queue.push_back(pack_coefs(0, -32768, 32767));
      coef_queue.push_back(pack_coefs(0, 1, -32768));
      coef_queue.push_back(pack_coefs(0, -1, 32767));
      coef_queue.push_back(pack_coefs(1, -3, 2));
      coef_queue.push_back(pack_coefs(1, 2, 5));
      coef_queue.push_back(pack_coefs(1, 2, 1));
      coef_queue.push_back(pack_coefs(1, 0, -4));
      coef_queue.push_back(pack_coefs(1, 0, 4));
      coef_queue.push_back(pack_coefs(-1, 0, 4));
      coef_queue.push_back(pack_coefs(-3, 0, -5));
      coef_queue.push_back(pack_coefs(2, 5, 0));
      coef_queue.push_back(pack_coefs(-32768, -32768, -32768));
      coef_queue.push_back(pack_coefs(32767, 32767, 32767));
      coef_queue.push_back(pack_coefs(-32768, 32767, -32768));
      coef_queue.push_back(pack_coefs(32767, -32768, 32767));
      coef_queue.push_back(pack_coefs(1, -32768, -32768));
      coef_queue.push_back(pack_coefs(-1, 32767, 32767));
      coef_queue.push_back(pack_coefs(-32768, 0, 32767));
      for (i = 0; i < 1950; i++) begin
         mode = $urandom_range(0, 9);
         a = $signed(16'($urandom));
         b = $signed(16'($urandom));
         c = $signed(16'($urandom));
         case (mode)
            0: a = 0;
            1: begin
               a = 0;
               if ($urandom_range(0, 3) == 0) b = 0;
            end
            2: b = 0;
            3: begin
               a = $urandom_range(0, 40) - 20;
               b = $urandom_range(0, 80) - 40;
               c = $urandom_range(0, 40) - 20;
            end
            4: begin
               // Integer roots a*(x-p)*(x-q) keep the discriminant a perfect square.
               k = $urandom_range(1, 5);
               a = ($urandom_range(0, 1) != 0) ? k : -k;
               b = $urandom_range(0, 40) - 20;
               c = $urandom_range(0, 40) - 20;
               {b, c} = {-a * (b + c), a * b * c};
            end
            default: ;
         endcase
         coef_queue.push_back(pack_coefs(a, b, c));
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (coef_queue.size() == 0 && !req_tvalid && expected_roots.size() == 0);
      repeat (150) @(posedge clock);
      if (mismatches == 0 && expected_roots.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
